[src/lgs_pkg.sv]
// Shared types and constants for the life grid generation step block.
package lgs_pkg;

   localparam int ROW_W = 5;
   localparam int COL_W = 6;

   localparam logic [1:0] ACT_WRITE   = 2'd0;
   localparam logic [1:0] ACT_READ    = 2'd1;
   localparam logic [1:0] ACT_ADVANCE = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CELL,
      ST_SWEEP,
      ST_DRAIN
   } lgs_state_type;

   typedef struct packed {
      logic [1:0]       action;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] column;
      logic             value;
   } lgs_req_type;

   typedef struct packed {
      logic cell_value;
      logic generation_done;
   } lgs_rsp_type;

   typedef struct packed {
      logic        valid;
      lgs_rsp_type rsp;
   } lgs_done_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } lgs_mem_ctl_type;

endpackage

[src/lgs_row_mem.sv]
// Grid row memory with one write port and one registered read port.
module lgs_row_mem
   import lgs_pkg::*;
#(
   parameter int DEPTH = 32,
   parameter int WIDTH = 64
) (
   input  logic                     clock,
   input  lgs_mem_ctl_type          ctl,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] row_mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         row_mem_ff[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= row_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/lgs_row_rule.sv]
// Next-generation logic for one grid row from the old rows above, at and below it.
module lgs_row_rule
   import lgs_pkg::*;
#(
   parameter int WIDTH = 64
) (
   input  logic [WIDTH-1:0] above,
   input  logic [WIDTH-1:0] mid,
   input  logic [WIDTH-1:0] below,
   output logic [WIDTH-1:0] next_row
);

   localparam logic [3:0] BIRTH_COUNT   = 4'd3;
   localparam logic [3:0] SURVIVE_COUNT = 4'd2;

   always_comb begin
      logic [3:0] nbr_cnt;
      nbr_cnt  = '0;
      next_row = mid;
      for (int c = 1; c < WIDTH - 1; c++) begin
         nbr_cnt = 4'(above[c-1]) + 4'(above[c]) + 4'(above[c+1])
                 + 4'(mid[c-1]) + 4'(mid[c+1])
                 + 4'(below[c-1]) + 4'(below[c]) + 4'(below[c+1]);
         if (mid[c]) begin
            next_row[c] = (nbr_cnt == SURVIVE_COUNT) || (nbr_cnt == BIRTH_COUNT);
         end else begin
            next_row[c] = (nbr_cnt == BIRTH_COUNT);
         end
      end
   end

endmodule

[src/lgs_seq.sv]
// Sequencer that clears, reads, writes and sweeps the grid memory row by row.
module lgs_seq
   import lgs_pkg::*;
#(
   parameter int GRID_HEIGHT = 32,
   parameter int GRID_WIDTH  = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_accept,
   input  lgs_req_type                    req,
   input  logic [GRID_WIDTH-1:0]          rd_data,
   input  logic [GRID_WIDTH-1:0]          rule_next,
   output logic                           idle,
   output lgs_mem_ctl_type                mem_ctl,
   output logic [$clog2(GRID_HEIGHT)-1:0] rd_addr,
   output logic [$clog2(GRID_HEIGHT)-1:0] wr_addr,
   output logic [GRID_WIDTH-1:0]          wr_data,
   output logic [GRID_WIDTH-1:0]          rule_above,
   output logic [GRID_WIDTH-1:0]          rule_mid,
   output lgs_done_type                   done
);

   localparam int AW = $clog2(GRID_HEIGHT);
   localparam int CW = $clog2(GRID_WIDTH);
   localparam logic [AW-1:0] LAST_ROW = AW'(GRID_HEIGHT - 1);

   lgs_state_type   state_ff, state_in;
   logic [AW-1:0]   cnt_ff, cnt_in;
   logic            pend_ff;
   logic [AW-1:0]   pend_row_ff;
   logic [GRID_WIDTH-1:0] up_ff, mid_ff;
   logic [1:0]      act_ff;
   logic [AW-1:0]   addr_ff;
   logic [CW-1:0]   col_ff;
   logic            val_ff;
   logic            inside_ff;

   logic [AW-1:0]   req_addr;
   logic            req_inside;
   logic            req_cell;
   logic            pend_wr;
   logic [GRID_WIDTH-1:0] cell_word;

   assign req_addr   = AW'(req.row);
   assign req_inside = (32'(req.row) < 32'(GRID_HEIGHT))
                    && (32'(req.column) < 32'(GRID_WIDTH));
   assign req_cell   = (req.action == ACT_READ) || (req.action == ACT_WRITE);
   assign pend_wr    = pend_ff && (pend_row_ff >= AW'(2));

   always_comb begin
      cell_word         = rd_data;
      cell_word[col_ff] = val_ff;
   end

   assign idle       = (state_ff == ST_IDLE);
   assign rule_above = up_ff;
   assign rule_mid   = mid_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cnt_in = cnt_ff + AW'(1);
            if (cnt_ff == LAST_ROW) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            cnt_in = '0;
            if (req_accept) begin
               if (req.action == ACT_ADVANCE) begin
                  state_in = ST_SWEEP;
               end else if (req_cell) begin
                  state_in = ST_CELL;
               end
            end
         end
         ST_CELL: begin
            state_in = ST_IDLE;
         end
         ST_SWEEP: begin
            cnt_in = cnt_ff + AW'(1);
            if (cnt_ff == LAST_ROW) begin
               cnt_in   = '0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      mem_ctl = '0;
      rd_addr = cnt_ff;
      wr_addr = cnt_ff;
      wr_data = '0;
      done    = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_ctl.wr_en = 1'b1;
         end
         ST_IDLE: begin
            rd_addr       = req_addr;
            mem_ctl.rd_en = req_accept && req_cell && req_inside;
            done.valid    = req_accept && !req_cell && (req.action != ACT_ADVANCE);
         end
         ST_CELL: begin
            mem_ctl.wr_en = (act_ff == ACT_WRITE) && inside_ff;
            wr_addr       = addr_ff;
            wr_data       = cell_word;
            done.valid    = 1'b1;
            done.rsp.cell_value = (act_ff == ACT_READ) && inside_ff && rd_data[col_ff];
         end
         ST_SWEEP: begin
            mem_ctl.rd_en = 1'b1;
            mem_ctl.wr_en = pend_wr;
            wr_addr       = pend_row_ff - AW'(1);
            wr_data       = rule_next;
         end
         ST_DRAIN: begin
            mem_ctl.wr_en = pend_wr;
            wr_addr       = pend_row_ff - AW'(1);
            wr_data       = rule_next;
            done.valid    = 1'b1;
            done.rsp.generation_done = 1'b1;
         end
         default: begin
            mem_ctl = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         pend_ff  <= (state_ff == ST_SWEEP);
      end
   end

   always_ff @(posedge clock) begin
      pend_row_ff <= cnt_ff;
      if (pend_ff) begin
         up_ff  <= mid_ff;
         mid_ff <= rd_data;
      end
      if (req_accept) begin
         act_ff    <= req.action;
         addr_ff   <= req_addr;
         col_ff    <= CW'(req.column);
         val_ff    <= req.value;
         inside_ff <= req_inside;
      end
   end

   a_wr_behind_rd: assert property (@(posedge clock) disable iff (reset)
      (mem_ctl.wr_en && mem_ctl.rd_en) |-> (wr_addr != rd_addr))
      else $error("Sweep wrote the row it is reading.");

   a_drain_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> (pend_ff && (pend_row_ff == LAST_ROW)))
      else $error("Sweep ended before the last row arrived.");

   a_done_state: assert property (@(posedge clock) disable iff (reset)
      done.valid |-> ((state_ff != ST_SWEEP) && (state_ff != ST_CLEAR)))
      else $error("Result issued in the middle of a sweep or clear.");

   a_gen_done: assert property (@(posedge clock) disable iff (reset)
      done.rsp.generation_done |-> (done.valid && $past(state_ff) == ST_SWEEP))
      else $error("Generation reported without a full sweep.");

endmodule

[src/life_grid_generation_step_top.sv]
// Top level of the life grid generation step block with its response register.
//
// The grid is kept one row per memory word in a single memory with one read
// and one write port. After reset a clearing pass writes every row dead,
// during which no word is accepted. A read or write word first reads its row,
// then the bit is returned or written back; an unused action code is answered
// without a memory access. An advance reads one row per cycle through the read
// port while the new row lagging two rows behind is written, and a final drain
// step writes the last new row. A new word is accepted once the previous one
// is finished and the response register is free or being emptied.
module life_grid_generation_step_top
   import lgs_pkg::*;
#(
   parameter int GRID_HEIGHT = 32,
   parameter int GRID_WIDTH  = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  lgs_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output lgs_rsp_type rsp_data
);

   localparam int AW = $clog2(GRID_HEIGHT);

   logic                  seq_idle;
   logic                  req_accept;
   lgs_mem_ctl_type       mem_ctl;
   logic [AW-1:0]         rd_addr, wr_addr;
   logic [GRID_WIDTH-1:0] wr_data, rd_data;
   logic [GRID_WIDTH-1:0] rule_above, rule_mid, rule_next;
   lgs_done_type          done;

   logic                  rsp_valid_ff, rsp_valid_in;
   lgs_rsp_type           rsp_data_ff;

   assign req_ready  = seq_idle && (!rsp_valid_ff || rsp_ready);
   assign req_accept = req_valid && req_ready;

   lgs_seq #(
      .GRID_HEIGHT(GRID_HEIGHT),
      .GRID_WIDTH (GRID_WIDTH)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_accept(req_accept),
      .req       (req_data),
      .rd_data   (rd_data),
      .rule_next (rule_next),
      .idle      (seq_idle),
      .mem_ctl   (mem_ctl),
      .rd_addr   (rd_addr),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rule_above(rule_above),
      .rule_mid  (rule_mid),
      .done      (done)
   );

   lgs_row_mem #(
      .DEPTH(GRID_HEIGHT),
      .WIDTH(GRID_WIDTH)
   ) u_mem (
      .clock  (clock),
      .ctl    (mem_ctl),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   lgs_row_rule #(
      .WIDTH(GRID_WIDTH)
   ) u_rule (
      .above   (rule_above),
      .mid     (rule_mid),
      .below   (rd_data),
      .next_row(rule_next)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (done.valid) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done.valid) begin
         rsp_data_ff <= done.rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[verif/tb_life_grid_generation_step_top.sv]
// Self-checking testbench for the life grid step block: cell access, generation advance, stalls.
`timescale 1ns / 100ps

module tb_life_grid_generation_step_top;
   import lgs_pkg::*;

   localparam int GRID_HEIGHT = 32;
   localparam int GRID_WIDTH  = 64;
   localparam int STALL_LIMIT = 4000;
   localparam int TAIL_CYCLES = 80;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   lgs_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   lgs_rsp_type rsp_data;

   bit [GRID_WIDTH-1:0] life_grid [GRID_HEIGHT];
   lgs_rsp_type         expected_cell_results [$];

   int send_idle_pct   = 0;
   int rsp_stall_pct   = 0;
   int rsp_hold_cycles = 0;
   int words_sent      = 0;
   int error_count     = 0;
   int quiet_cycles    = 0;

   life_grid_generation_step_top #(
      .GRID_HEIGHT(GRID_HEIGHT),
      .GRID_WIDTH (GRID_WIDTH)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always #5 clock = ~clock;

   function automatic void life_advance();
      bit [GRID_WIDTH-1:0] row_above;
      bit [GRID_WIDTH-1:0] row_old;
      bit [GRID_WIDTH-1:0] row_below;
      bit [GRID_WIDTH-1:0] fresh;
      int                  n;
      row_above = life_grid[0];
      for (int r = 1; r < GRID_HEIGHT - 1; r++) begin
         row_old   = life_grid[r];
         row_below = life_grid[r + 1];
         fresh     = row_old;
         for (int c = 1; c < GRID_WIDTH - 1; c++) begin
            n = int'(row_above[c-1]) + int'(row_above[c]) + int'(row_above[c+1])
              + int'(row_old[c-1]) + int'(row_old[c+1])
              + int'(row_below[c-1]) + int'(row_below[c]) + int'(row_below[c+1]);
            if (row_old[c]) begin
               if (n <= 1 || n >= 4) fresh[c] = 1'b0;
            end else if (n == 3) begin
               fresh[c] = 1'b1;
            end
         end
         life_grid[r] = fresh;
         row_above    = row_old;
      end
   endfunction

   function automatic lgs_rsp_type life_step_predict(input lgs_req_type w);
      lgs_rsp_type r;
      bit          on_grid;
      r       = '0;
      on_grid = (int'(w.row) < GRID_HEIGHT) && (int'(w.column) < GRID_WIDTH);
      case (w.action)
         ACT_WRITE: begin
            if (on_grid) life_grid[w.row][w.column] = w.value;
         end
         ACT_READ: begin
            if (on_grid) r.cell_value = life_grid[w.row][w.column];
         end
         ACT_ADVANCE: begin
            life_advance();
            r.generation_done = 1'b1;
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   function automatic lgs_req_type make_word(input logic [1:0] action, input int row,
                                             input int column, input bit value);
      lgs_req_type w;
      w.action = action;
      w.row    = row[ROW_W-1:0];
      w.column = column[COL_W-1:0];
      w.value  = value;
      return w;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("[%0t] mismatch: %s got %0d expected %0d", $time, what, got, want);
      error_count++;
   endtask

   task automatic send_word(input lgs_req_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_cell_results.push_back(life_step_predict(w));
      words_sent++;
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_cell_results.size() != 0) @(posedge clock);
   endtask

   task automatic send_random_cell(input logic [1:0] action);
      send_word(make_word(action, $urandom_range(GRID_HEIGHT - 1),
                          $urandom_range(GRID_WIDTH - 1), 1'($urandom_range(1))));
   endtask

   task automatic send_pattern_episode();
      int top;
      int left;
      int tall;
      int wide;
      int alive_pct;
      tall      = $urandom_range(3, 12);
      wide      = $urandom_range(3, 20);
      top       = $urandom_range(GRID_HEIGHT - tall);
      left      = $urandom_range(GRID_WIDTH - wide);
      alive_pct = $urandom_range(25, 75);
      repeat ($urandom_range(5, 25)) begin
         send_word(make_word(ACT_WRITE, top + $urandom_range(tall - 1),
                             left + $urandom_range(wide - 1),
                             $urandom_range(99) < alive_pct));
      end
      repeat ($urandom_range(1, 4)) begin
         send_random_cell(ACT_ADVANCE);
         repeat ($urandom_range(1, 6)) begin
            send_word(make_word(ACT_READ, top + $urandom_range(tall - 1),
                                left + $urandom_range(wide - 1),
                                1'($urandom_range(1))));
         end
      end
   endtask

   task automatic run_directed_cases();
      send_word(make_word(ACT_READ, 0, 0, 1'b0));
      send_word(make_word(ACT_READ, GRID_HEIGHT - 1, GRID_WIDTH - 1, 1'b0));
      send_word(make_word(ACT_WRITE, 0, 0, 1'b1));
      send_word(make_word(ACT_WRITE, 0, GRID_WIDTH - 1, 1'b1));
      send_word(make_word(ACT_WRITE, GRID_HEIGHT - 1, 0, 1'b1));
      send_word(make_word(ACT_WRITE, GRID_HEIGHT - 1, GRID_WIDTH - 1, 1'b1));
      for (int r = 10; r <= 12; r++) send_word(make_word(ACT_WRITE, r, 20, 1'b1));
      for (int c = 30; c <= 32; c++) send_word(make_word(ACT_WRITE, 0, c, 1'b1));
      send_word(make_word(ACT_ADVANCE, GRID_HEIGHT - 1, GRID_WIDTH - 1, 1'b1));
      send_word(make_word(ACT_READ, 11, 19, 1'b0));
      send_word(make_word(ACT_READ, 11, 21, 1'b0));
      send_word(make_word(ACT_READ, 10, 20, 1'b0));
      send_word(make_word(ACT_READ, 0, 0, 1'b0));
      send_word(make_word(ACT_READ, 1, 31, 1'b0));
      send_word(make_word(ACT_READ, 0, 31, 1'b0));
      send_word(make_word(2'b11, GRID_HEIGHT - 1, GRID_WIDTH - 1, 1'b1));
      send_word(make_word(ACT_READ, 11, 20, 1'b1));
      send_word(make_word(ACT_WRITE, GRID_HEIGHT - 1, GRID_WIDTH - 1, 1'b0));
      send_word(make_word(ACT_READ, GRID_HEIGHT - 1, GRID_WIDTH - 1, 1'b0));
      wait_for_drain();
   endtask

   task automatic run_random_traffic(input int idle_pct, input int stall_pct,
                                     input int word_budget);
      int start;
      int pick;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      start         = words_sent;
      while (words_sent - start < word_budget) begin
         pick = $urandom_range(99);
         if (pick < 60) begin
            send_pattern_episode();
         end else if (pick < 78) begin
            send_random_cell(ACT_READ);
         end else if (pick < 93) begin
            send_random_cell(ACT_WRITE);
         end else if (pick < 97) begin
            send_random_cell(2'b11);
         end else begin
            send_random_cell(ACT_ADVANCE);
         end
      end
      wait_for_drain();
   endtask

   task automatic run_response_hold_off();
      send_idle_pct   = 0;
      rsp_stall_pct   = 0;
      rsp_hold_cycles = 300;
      repeat (20) send_random_cell(ACT_READ);
      send_random_cell(ACT_ADVANCE);
      repeat (10) send_random_cell(ACT_WRITE);
      wait_for_drain();
   endtask

   always @(posedge clock) begin
      lgs_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_cell_results.size() == 0) begin
            report_mismatch("result word with nothing expected", 1, 0);
         end else begin
            want = expected_cell_results.pop_front();
            if (rsp_data.cell_value !== want.cell_value)
               report_mismatch("cell_value", int'(rsp_data.cell_value),
                               int'(want.cell_value));
            if (rsp_data.generation_done !== want.generation_done)
               report_mismatch("generation_done", int'(rsp_data.generation_done),
                               int'(want.generation_done));
         end
      end
      if (rsp_hold_cycles > 0) begin
         rsp_hold_cycles--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   initial begin
      foreach (life_grid[r]) life_grid[r] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      run_directed_cases();
      run_random_traffic(0, 0, 290);
      run_random_traffic(77, 0, 290);
      run_random_traffic(0, 77, 290);
      run_random_traffic(14, 14, 290);
      run_response_hold_off();
      run_random_traffic(0, 0, 40);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_cell_results.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

[filelist.f]
src/lgs_pkg.sv
src/lgs_row_mem.sv
src/lgs_row_rule.sv
src/lgs_seq.sv
src/life_grid_generation_step_top.sv
verif/tb_life_grid_generation_step_top.sv
